/* rtl/core/aupg_pkg.sv */
// shared types and constants of the audio underrun timestamp governor
`default_nettype none

package aupg_pkg;

  // timestamp, duration and count widths, plus the widened sum width
  localparam int TS_W  = 48;
  localparam int DUR_W = 24;
  localparam int CNT_W = 8;
  localparam int XW    = TS_W + 2;

  // configuration port
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER_MARGIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT  = 2'd3;

  localparam logic [TS_W-1:0]  TS_MAX  = {TS_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // stream widths
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 128;
  localparam int ACT_W      = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_PASS    = 3'd0,
    ACT_RETIME  = 3'd1,
    ACT_DROP    = 3'd2,
    ACT_SYNTH   = 3'd3,
    ACT_REPEAT  = 3'd4,
    ACT_NONE    = 3'd5
  } action_t;

  typedef struct packed {
    logic             req_type;
    logic [TS_W-1:0]  clock_ref;
    logic [TS_W-1:0]  frame_pts;
    logic             pts_valid;
    logic [DUR_W-1:0] frame_duration;
    logic             duration_valid;
    logic             filler_ready;
    logic [DUR_W-1:0] filler_duration;
  } item_t;

  typedef struct packed {
    action_t          action;
    logic [TS_W-1:0]  out_pts;
    logic [DUR_W-1:0] out_duration;
    logic [TS_W-1:0]  delay_now;
    logic             underrun_hit;
  } result_t;

  typedef struct packed {
    logic [TS_W-1:0]  extra_delay;
    logic [TS_W-1:0]  last_ingress_pts;
    logic [DUR_W-1:0] last_duration;
    logic             last_pts_known;
    logic             last_duration_known;
    logic [CNT_W-1:0] repeat_counter;
  } state_t;

  typedef struct packed {
    logic [DUR_W-1:0] base_delay;
    logic [DUR_W-1:0] min_delay;
    logic [DUR_W-1:0] jitter_margin;
    logic [CNT_W-1:0] repeat_limit;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/aupg_in_stage.sv */
// input register stage holding one accepted item
`default_nettype none

module aupg_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire aupg_pkg::item_t in_item,
  input  wire logic          advance,
  output logic               held_valid,
  output aupg_pkg::item_t    held_item
);
  import aupg_pkg::*;

  // stage frees up when its item moves on
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/aupg_step.sv */
// per-item retiming, drop and filler decision with next state
`default_nettype none

module aupg_step (
  input  wire aupg_pkg::item_t  item,
  input  wire aupg_pkg::state_t st,
  input  wire aupg_pkg::cfg_t   cfg,
  output aupg_pkg::result_t     res,
  output aupg_pkg::state_t      st_next
);
  import aupg_pkg::*;

  logic [XW-1:0]    pts_x, pcr_x, extra_x, base_x, min_x, jit_x, dur_x;
  logic [XW-1:0]    epts, flr, flr_jd, lift;
  logic [TS_W-1:0]  lift_sat, ext_mid, ext_frame, opts_frame;
  logic             hit, roomy, drop;
  logic [DUR_W-1:0] dur_eff;
  logic [XW-1:0]    nxt, lim;
  logic             late, synth, filler_ok;
  logic [CNT_W-1:0] rc_inc;
  logic [DUR_W-1:0] fill_dur;
  logic [TS_W:0]    fill_sum;
  logic [TS_W-1:0]  ext_fill;

  // operands widened so no sum wraps
  assign pts_x   = {2'b00, item.frame_pts};
  assign pcr_x   = {2'b00, item.clock_ref};
  assign extra_x = {2'b00, st.extra_delay};
  assign base_x  = {{(XW-DUR_W){1'b0}}, cfg.base_delay};
  assign min_x   = {{(XW-DUR_W){1'b0}}, cfg.min_delay};
  assign jit_x   = {{(XW-DUR_W){1'b0}}, cfg.jitter_margin};
  assign dur_x   = {{(XW-DUR_W){1'b0}}, item.frame_duration};
  assign dur_eff = item.duration_valid ? item.frame_duration : '0;

  // arrived frame: egress time, floor and underrun lift in parallel
  assign epts   = pts_x + extra_x + base_x;
  assign flr    = pcr_x + min_x;
  assign flr_jd = flr + jit_x + dur_x;
  assign hit    = epts < flr;
  // extra delay after a lift is floor minus the undelayed egress time
  assign lift     = flr - pts_x - base_x;
  assign lift_sat = (|lift[XW-1:TS_W]) ? TS_MAX : lift[TS_W-1:0];
  assign ext_mid  = hit ? lift_sat : st.extra_delay;

  // recovery: after a lift the slack is zero, so only a zero need passes
  assign roomy = hit ? ((cfg.jitter_margin == '0) && (item.frame_duration == '0))
                     : (epts >= flr_jd);
  assign drop  = (ext_mid != '0) && item.duration_valid && roomy &&
                 (ext_mid >= {{(TS_W-DUR_W){1'b0}}, item.frame_duration});
  assign ext_frame  = drop ? ext_mid - {{(TS_W-DUR_W){1'b0}}, item.frame_duration}
                           : ext_mid;
  assign opts_frame = drop ? '0 : (hit ? flr[TS_W-1:0] : epts[TS_W-1:0]);

  // no frame: is the next slot late
  assign nxt = {2'b00, st.last_ingress_pts}
             + {{(XW-DUR_W){1'b0}}, st.last_duration} + extra_x + base_x;
  assign lim  = pcr_x + min_x + jit_x;
  assign late = nxt < lim;
  assign filler_ok = st.last_pts_known && st.last_duration_known && late;

  // repeat count and filler kind
  assign rc_inc   = (st.repeat_counter == CNT_MAX) ? st.repeat_counter
                                                   : st.repeat_counter + 1'b1;
  assign synth    = (rc_inc > cfg.repeat_limit) && item.filler_ready;
  assign fill_dur = synth ? item.filler_duration : st.last_duration;
  assign fill_sum = {1'b0, st.extra_delay} + {{(TS_W+1-DUR_W){1'b0}}, fill_dur};
  assign ext_fill = fill_sum[TS_W] ? TS_MAX : fill_sum[TS_W-1:0];

  // pick result and next state
  always_comb begin
    st_next          = st;
    res.action       = ACT_NONE;
    res.out_pts      = '0;
    res.out_duration = '0;
    res.underrun_hit = 1'b0;
    if (!item.req_type) begin
      res.out_duration = dur_eff;
      if (!item.pts_valid) begin
        res.action  = ACT_PASS;
        res.out_pts = item.frame_pts;
      end else begin
        res.action       = drop ? ACT_DROP : ACT_RETIME;
        res.out_pts      = opts_frame;
        res.underrun_hit = hit;
        st_next.extra_delay         = ext_frame;
        st_next.last_ingress_pts    = item.frame_pts;
        st_next.last_duration       = dur_eff;
        st_next.last_pts_known      = 1'b1;
        st_next.last_duration_known = item.duration_valid;
        st_next.repeat_counter      = '0;
      end
    end else if (filler_ok) begin
      res.action       = synth ? ACT_SYNTH : ACT_REPEAT;
      res.out_pts      = nxt[TS_W-1:0];
      res.out_duration = fill_dur;
      st_next.extra_delay    = ext_fill;
      st_next.repeat_counter = rc_inc;
    end
    res.delay_now = st_next.extra_delay;
  end

endmodule

`default_nettype wire

/* rtl/core/audio_underrun_pts_governor_unit.sv */
// top level of the audio underrun timestamp governor
//
// One result item per input item. Items are accepted back to back, one per
// clock, as long as m_axis_tready keeps the result register draining; each
// item waits in the input register until the result register is free or
// being drained, and its result is then loaded into the output register,
// raising m_axis_tvalid. Throughput is set by the combinational loop from
// the delay and repeat state through the step logic and back. s_axis_tready
// follows m_axis_tready in the same cycle when both stages are full. The
// user must write configuration through cfg_wr_en, cfg_index and cfg_data
// only while no item is in flight; the block itself does not enforce this.
`default_nettype none

module audio_underrun_pts_governor_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration writes
  input  wire logic                                 cfg_wr_en,
  input  wire logic [aupg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [aupg_pkg::CFG_W-1:0]           cfg_data,
  // input items
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // clock_ref[47:0], frame_pts[95:48], pts_valid[96], frame_duration[120:97],
  // duration_valid[121], filler_ready[122], filler_duration[146:123], zeros
  input  wire logic [aupg_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // req_type[0]
  input  wire logic                                 s_axis_tuser,
  // result items
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // out_pts[47:0], out_duration[71:48], delay_now[119:72], underrun_hit[120],
  // zeros
  output logic [aupg_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
  // action[2:0]
  output logic [aupg_pkg::ACT_W-1:0]                m_axis_tuser
);
  import aupg_pkg::*;

  item_t   in_item, held_item;
  logic    held_valid, advance;
  state_t  st, st_next;
  cfg_t    cfg;
  result_t res, res_q;

  // unpack the input item
  assign in_item.req_type        = s_axis_tuser;
  assign in_item.clock_ref       = s_axis_tdata[47:0];
  assign in_item.frame_pts       = s_axis_tdata[95:48];
  assign in_item.pts_valid       = s_axis_tdata[96];
  assign in_item.frame_duration  = s_axis_tdata[120:97];
  assign in_item.duration_valid  = s_axis_tdata[121];
  assign in_item.filler_ready    = s_axis_tdata[122];
  assign in_item.filler_duration = s_axis_tdata[146:123];

  aupg_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  aupg_step u_step (
    .item    (held_item),
    .st      (st),
    .cfg     (cfg),
    .res     (res),
    .st_next (st_next)
  );

  // item moves on when the result register is free or being drained
  assign advance = held_valid && (!m_axis_tvalid || m_axis_tready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BASE_DELAY:    cfg.base_delay    <= cfg_data[DUR_W-1:0];
        CFG_MIN_DELAY:     cfg.min_delay     <= cfg_data[DUR_W-1:0];
        CFG_JITTER_MARGIN: cfg.jitter_margin <= cfg_data[DUR_W-1:0];
        CFG_REPEAT_LIMIT:  cfg.repeat_limit  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // delay and filler state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  // pack the result item
  assign m_axis_tuser = res_q.action;
  assign m_axis_tdata = {{(OUT_DATA_W-2*TS_W-DUR_W-1){1'b0}}, res_q.underrun_hit,
                         res_q.delay_now, res_q.out_duration, res_q.out_pts};

endmodule

`default_nettype wire

/* rtl/core/aupg_checker.sv */
// port-level checks of the governor, bound to the top level
`default_nettype none

module aupg_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [aupg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic [aupg_pkg::ACT_W-1:0]     m_axis_tuser
);
  import aupg_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid after reset");

  // only an arrived frame can be lifted
  a_hit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[120] |->
      (m_axis_tuser == ACT_RETIME) || (m_axis_tuser == ACT_DROP))
    else $error("underrun flag on a result that is no retimed frame");

  // no-output result carries zero timestamp and duration
  a_none: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ACT_NONE) |->
      (m_axis_tdata[71:0] == '0) && !m_axis_tdata[120])
    else $error("empty result carries data");

  // a dropped frame has no egress timestamp
  a_drop: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ACT_DROP) |-> (m_axis_tdata[47:0] == '0))
    else $error("dropped frame with a timestamp");

endmodule

bind audio_underrun_pts_governor_unit aupg_checker u_aupg_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
